>>> rtl/core/sfc_pkg.sv
package sfc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_GRID  = 256;
   localparam int SIZE_W    = 9;
   localparam int POS_W     = 8;
   localparam int VAL_W     = 32;
   localparam int K_W       = 10;
   localparam int KSQ_W     = 18;
   localparam int PROD_W    = 2 * VAL_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int LANE_W    = PAIR_W + K_W;
   localparam int NUM_W     = LANE_W + 2;
   localparam int MAG_W     = NUM_W - 1;
   localparam int QUO_W     = VAL_W + 1;
   localparam int HIGH_W    = MAG_W - FRAC_BITS - QUO_W;
   localparam int IDX_W     = 2;
   localparam int LAT       = 5;

   localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0]        pos_x;
      logic [POS_W-1:0]        pos_y;
      logic [POS_W-1:0]        pos_z;
      logic signed [VAL_W-1:0] force_x_re;
      logic signed [VAL_W-1:0] force_x_im;
      logic signed [VAL_W-1:0] force_y_re;
      logic signed [VAL_W-1:0] force_y_im;
      logic signed [VAL_W-1:0] force_z_re;
      logic signed [VAL_W-1:0] force_z_im;
      logic signed [VAL_W-1:0] dens_re;
      logic signed [VAL_W-1:0] dens_im;
   } req_data_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_re;
      logic signed [VAL_W-1:0] out_im;
   } rsp_data_type;

   typedef struct packed {
      logic [KSQ_W-1:0]     rem;
      logic [QUO_W-1:0]     abits;
      logic [QUO_W-1:0]     quo;
      logic [FRAC_BITS-1:0] frac;
      logic                 neg;
      logic                 ovf;
   } div_word_type;

   typedef struct packed {
      logic             valid;
      logic [KSQ_W-1:0] den;
   } div_ctl_type;

endpackage

>>> rtl/core/sfc_lane.sv
module sfc_lane
   import sfc_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [K_W-1:0]    k,
   input  logic signed [VAL_W-1:0]  fre,
   input  logic signed [VAL_W-1:0]  fim,
   input  logic signed [VAL_W-1:0]  gre,
   input  logic signed [VAL_W-1:0]  gim,
   output logic signed [LANE_W-1:0] sum_re,
   output logic signed [LANE_W-1:0] sum_im,
   output logic [KSQ_W-1:0]         ksq
);

   logic signed [PROD_W-1:0] p_rg_ff, p_ig_ff, p_ii_ff, p_rr_ff;
   logic signed [K_W-1:0]    k1_ff, k2_ff;
   logic signed [PAIR_W-1:0] pr_ff, pi_ff;
   logic signed [LANE_W-1:0] sre_ff, sim_ff;
   logic [KSQ_W-1:0]         ksq_ff;
   logic signed [2*K_W-1:0]  ksq_in;

   assign ksq_in = k2_ff * k2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_rg_ff <= fre * gim;
         p_ig_ff <= fim * gre;
         p_ii_ff <= fim * gim;
         p_rr_ff <= fre * gre;
         k1_ff   <= k;
         pr_ff   <= PAIR_W'(p_rg_ff) + PAIR_W'(p_ig_ff);
         pi_ff   <= PAIR_W'(p_ii_ff) - PAIR_W'(p_rr_ff);
         k2_ff   <= k1_ff;
         sre_ff  <= LANE_W'(pr_ff) * LANE_W'(k2_ff);
         sim_ff  <= LANE_W'(pi_ff) * LANE_W'(k2_ff);
         ksq_ff  <= ksq_in[KSQ_W-1:0];
      end
   end

   assign sum_re = sre_ff;
   assign sum_im = sim_ff;
   assign ksq    = ksq_ff;

endmodule

>>> rtl/core/sfc_div_step.sv
module sfc_div_step
   import sfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  div_ctl_type  ctl_in,
   input  div_word_type re_in,
   input  div_word_type im_in,
   output div_ctl_type  ctl_out,
   output div_word_type re_out,
   output div_word_type im_out
);

   div_ctl_type  ctl_ff;
   div_word_type re_ff, im_ff, re_in_w, im_in_w;

   function automatic div_word_type step(div_word_type w, logic [KSQ_W-1:0] den);
      logic [KSQ_W:0] t;
      div_word_type   r;
      r = w;
      t = {w.rem, w.abits[QUO_W-1]};
      r.abits = {w.abits[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
         t = t - {1'b0, den};
         r.quo = {w.quo[QUO_W-2:0], 1'b1};
      end else begin
         r.quo = {w.quo[QUO_W-2:0], 1'b0};
      end
      r.rem = t[KSQ_W-1:0];
      return r;
   endfunction

   assign re_in_w = step(re_in, ctl_in.den);
   assign im_in_w = step(im_in, ctl_in.den);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.den <= ctl_in.den;
         re_ff      <= re_in_w;
         im_ff      <= im_in_w;
      end
   end

   assign ctl_out = ctl_ff;
   assign re_out  = re_ff;
   assign im_out  = im_ff;

endmodule

>>> rtl/core/spectral_force_convolution_point.sv
// Channel   | Ports                          | Payload
// ----------+--------------------------------+---------------------------------
// request   | req_valid, req_stall, req_data | indices, force and density spectra
// response  | rsp_valid, rsp_stall, rsp_data | saturated result spectrum
// config    | csr_we, csr_index, csr_wdata   | axis sizes, written any cycle
//
// One transfer is accepted per cycle while req_stall is low.
// Each request passes the 33 restoring division steps, one quotient bit per stage, before rsp_valid rises.
// Three axis lanes form the weighted products and a merge stage sums them.
// Reset clears the valid bits and sets each axis size to 64.
// A stalled response freezes the whole pipeline and raises req_stall.
module spectral_force_convolution_point
   import sfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_data_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_data_type      rsp_data,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [SIZE_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic              en;
   logic [LAT-1:0]    vld_ff;

   logic signed [K_W-1:0]   k_ff [3];
   logic signed [VAL_W-1:0] fre_ff [3];
   logic signed [VAL_W-1:0] fim_ff [3];
   logic signed [VAL_W-1:0] gre_ff, gim_ff;

   logic signed [LANE_W-1:0] lane_re [3];
   logic signed [LANE_W-1:0] lane_im [3];
   logic [KSQ_W-1:0]         lane_ksq [3];

   logic signed [NUM_W-1:0] sre_ff, sim_ff;
   logic [KSQ_W-1:0]        ksq_ff;

   div_ctl_type  ctl [QUO_W+1];
   div_word_type wre [QUO_W+1];
   div_word_type wim [QUO_W+1];

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   function automatic logic signed [K_W-1:0] wrap_freq(logic [POS_W-1:0] p,
                                                        logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] s;
      s = (size > SIZE_W'(MAX_GRID)) ? SIZE_W'(MAX_GRID) : size;
      if ({1'b0, p} <= (s >> 1)) begin
         return K_W'({1'b0, p});
      end
      return K_W'({1'b0, p}) - K_W'(s);
   endfunction

   function automatic div_word_type prep(logic signed [NUM_W-1:0] num,
                                         logic [KSQ_W-1:0] den);
      logic [MAG_W:0] mag;
      div_word_type   w;
      mag = num[NUM_W-1] ? MAG_W'(0) - num : num;
      w.neg   = num[NUM_W-1];
      w.frac  = mag[FRAC_BITS-1:0];
      w.abits = mag[FRAC_BITS +: QUO_W];
      w.ovf   = mag[MAG_W:FRAC_BITS+QUO_W] >= (HIGH_W+1)'(den);
      w.rem   = mag[FRAC_BITS+QUO_W +: KSQ_W];
      w.quo   = '0;
      return w;
   endfunction

   function automatic logic signed [VAL_W-1:0] finish(div_word_type w,
                                                       logic [KSQ_W-1:0] den);
      logic                  rnd;
      logic [QUO_W:0]        q;
      logic [QUO_W:0]        lim;
      logic [VAL_W-1:0]      m;
      rnd = {w.rem, w.frac, 1'b0} >= {1'b0, den, FRAC_BITS'(0)};
      q   = {1'b0, w.quo} + (QUO_W+1)'(rnd);
      lim = w.neg ? (QUO_W+1)'(34'h080000000) : (QUO_W+1)'(34'h07FFFFFFF);
      m   = (w.ovf || q > lim) ? lim[VAL_W-1:0] : q[VAL_W-1:0];
      if (den == '0) begin
         return '0;
      end
      return w.neg ? VAL_W'(0) - m : m;
   endfunction

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_W'(64);
         size_y_ff <= SIZE_W'(64);
         size_z_ff <= SIZE_W'(64);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SIZE_X: size_x_ff <= csr_wdata;
            REG_SIZE_Y: size_y_ff <= csr_wdata;
            REG_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_valid};
         rsp_valid_ff <= ctl[QUO_W].valid;
      end
      if (en) begin
         k_ff[0]  <= wrap_freq(req_data.pos_x, size_x_ff);
         k_ff[1]  <= wrap_freq(req_data.pos_y, size_y_ff);
         k_ff[2]  <= wrap_freq(req_data.pos_z, size_z_ff);
         fre_ff[0] <= req_data.force_x_re;
         fim_ff[0] <= req_data.force_x_im;
         fre_ff[1] <= req_data.force_y_re;
         fim_ff[1] <= req_data.force_y_im;
         fre_ff[2] <= req_data.force_z_re;
         fim_ff[2] <= req_data.force_z_im;
         gre_ff    <= req_data.dens_re;
         gim_ff    <= req_data.dens_im;
         sre_ff <= NUM_W'(lane_re[0]) + NUM_W'(lane_re[1]) + NUM_W'(lane_re[2]);
         sim_ff <= NUM_W'(lane_im[0]) + NUM_W'(lane_im[1]) + NUM_W'(lane_im[2]);
         ksq_ff <= lane_ksq[0] + lane_ksq[1] + lane_ksq[2];
         rsp_data_ff.out_re <= finish(wre[QUO_W], ctl[QUO_W].den);
         rsp_data_ff.out_im <= finish(wim[QUO_W], ctl[QUO_W].den);
      end
   end

   for (genvar d = 0; d < 3; d++) begin : g_lane
      sfc_lane u_lane (
         .clock  (clock),
         .en     (en),
         .k      (k_ff[d]),
         .fre    (fre_ff[d]),
         .fim    (fim_ff[d]),
         .gre    (gre_ff),
         .gim    (gim_ff),
         .sum_re (lane_re[d]),
         .sum_im (lane_im[d]),
         .ksq    (lane_ksq[d])
      );
   end

   assign ctl[0] = {vld_ff[LAT-1], ksq_ff};
   assign wre[0] = prep(sre_ff, ksq_ff);
   assign wim[0] = prep(sim_ff, ksq_ff);

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      sfc_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl[i]),
         .re_in   (wre[i]),
         .im_in   (wim[i]),
         .ctl_out (ctl[i+1]),
         .re_out  (wre[i+1]),
         .im_out  (wim[i+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
